// ----- sv/segment_segment_distance_3d_assert.svh -----
`ifndef SEGMENT_SEGMENT_DISTANCE_3D_ASSERT_SVH
`define SEGMENT_SEGMENT_DISTANCE_3D_ASSERT_SVH

// ante must be followed by cons in the same cycle
`define SSD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cond must never hold
`define SSD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- sv/ssd_pkg.sv -----
`default_nettype none

package ssd_pkg;

  localparam int FRAC_W     = 32;
  localparam int THR_W      = 32;
  localparam int DIST_W     = 17;
  localparam int COMP_W     = 27;
  localparam int RND_SHIFT  = 24;
  localparam int SQ_STEPS   = 28;
  localparam int SQ_W       = 2 * SQ_STEPS;
  localparam int DIST_SHIFT = 8;

  localparam logic [THR_W-1:0]  THR_RESET = 32'd42950;
  localparam logic [DIST_W-1:0] DIST_MAX  = 17'd131071;
  localparam logic [COMP_W-1:0] COMP_MAX  = 27'd67108864;

  typedef struct packed {
    logic zero;
    logic one;
  } ssd_flag_t;

endpackage

`default_nettype wire

// ----- sv/segment_segment_distance_3d.sv -----
`default_nettype none
`include "segment_segment_distance_3d_assert.svh"

// Shortest distance between two 3D segments. A request is taken in every cycle
// in which start is high; busy is always low. A result passes through 7 front
// stages (dot products, clamps), 33 in each parallel bit-per-stage divider, 5
// for the closest-point vector, 28 in the digit-per-stage square root and 1
// output register, and is shown with done_o high for one cycle only, since
// there is no way to hold it. The user must write parallel_threshold through
// cfg_we_i / cfg_data_i only while no request is in flight; nothing enforces it.

module segment_segment_distance_3d #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we_i,
  input  logic [ssd_pkg::THR_W-1:0]    cfg_data_i,
  input  logic signed [COORD_WIDTH-1:0] seg_a_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_a_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] seg_a_start_z_i,
  input  logic signed [COORD_WIDTH-1:0] seg_a_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_a_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] seg_a_end_z_i,
  input  logic signed [COORD_WIDTH-1:0] seg_b_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_b_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] seg_b_start_z_i,
  input  logic signed [COORD_WIDTH-1:0] seg_b_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_b_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] seg_b_end_z_i,
  output logic                         done_o,
  output logic [ssd_pkg::DIST_W-1:0]   seg_distance_o,
  output logic                         near_parallel_o
);
  import ssd_pkg::*;

  localparam int DW      = COORD_WIDTH + 1;
  localparam int PW      = 2 * DW;
  localparam int SW      = PW + 2;
  localparam int NW      = 2 * SW + 2;
  localparam int VW      = 9 * DW;
  localparam int PRW     = DW + FRAC_W + 2;
  localparam int PSW     = PRW + 2;
  localparam int DIV_LAT = FRAC_W + 1;
  localparam int LAT     = 7 + DIV_LAT + 5 + SQ_STEPS + 1;
  localparam logic [PSW-1:0] RND_HALF = PSW'(1) << (RND_SHIFT - 1);

  logic [THR_W-1:0] thr_q;
  logic             accept;
  logic [6:0]       fv_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      fv_q <= {fv_q[5:0], accept};
    end
  end

  // stage 1: direction and offset vectors
  logic signed [COORD_WIDTH-1:0] pa1 [3], pa2 [3], pb1 [3], pb2 [3];
  logic [VW-1:0] uvw_d, uvw1_q, uvw2_q, uvw3_q, uvw4_q, uvw5_q, uvw6_q, uvw7_q;

  assign pa1[0] = seg_a_start_x_i;
  assign pa1[1] = seg_a_start_y_i;
  assign pa1[2] = seg_a_start_z_i;
  assign pa2[0] = seg_a_end_x_i;
  assign pa2[1] = seg_a_end_y_i;
  assign pa2[2] = seg_a_end_z_i;
  assign pb1[0] = seg_b_start_x_i;
  assign pb1[1] = seg_b_start_y_i;
  assign pb1[2] = seg_b_start_z_i;
  assign pb2[0] = seg_b_end_x_i;
  assign pb2[1] = seg_b_end_y_i;
  assign pb2[2] = seg_b_end_z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      uvw_d[k*DW +: DW]     = DW'(pa2[k]) - DW'(pa1[k]);
      uvw_d[(3+k)*DW +: DW] = DW'(pb2[k]) - DW'(pb1[k]);
      uvw_d[(6+k)*DW +: DW] = DW'(pa1[k]) - DW'(pb1[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    uvw1_q <= uvw_d;
  end

  // stage 2: component products
  logic signed [DW-1:0] u1 [3], v1 [3], w1 [3];
  logic signed [PW-1:0] uu_q [3], uv_q [3], vv_q [3], uw_q [3], vw_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u1[k] = $signed(uvw1_q[k*DW +: DW]);
      v1[k] = $signed(uvw1_q[(3+k)*DW +: DW]);
      w1[k] = $signed(uvw1_q[(6+k)*DW +: DW]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      uu_q[k] <= u1[k] * u1[k];
      uv_q[k] <= u1[k] * v1[k];
      vv_q[k] <= v1[k] * v1[k];
      uw_q[k] <= u1[k] * w1[k];
      vw_q[k] <= v1[k] * w1[k];
    end
    uvw2_q <= uvw1_q;
  end

  // stage 3: dot products
  logic signed [SW-1:0] a3_q, b3_q, c3_q, d3_q, e3_q;

  always_ff @(posedge clk_i) begin
    a3_q   <= SW'(uu_q[0]) + SW'(uu_q[1]) + SW'(uu_q[2]);
    b3_q   <= SW'(uv_q[0]) + SW'(uv_q[1]) + SW'(uv_q[2]);
    c3_q   <= SW'(vv_q[0]) + SW'(vv_q[1]) + SW'(vv_q[2]);
    d3_q   <= SW'(uw_q[0]) + SW'(uw_q[1]) + SW'(uw_q[2]);
    e3_q   <= SW'(vw_q[0]) + SW'(vw_q[1]) + SW'(vw_q[2]);
    uvw3_q <= uvw2_q;
  end

  // stage 4: cross products of the dot products
  logic signed [2*SW-1:0] ac_q, bb_q, be_q, cd_q, ae_q, bd_q;
  logic signed [SW-1:0]   a4_q, b4_q, c4_q, d4_q, e4_q;

  always_ff @(posedge clk_i) begin
    ac_q   <= a3_q * c3_q;
    bb_q   <= b3_q * b3_q;
    be_q   <= b3_q * e3_q;
    cd_q   <= c3_q * d3_q;
    ae_q   <= a3_q * e3_q;
    bd_q   <= b3_q * d3_q;
    a4_q   <= a3_q;
    b4_q   <= b3_q;
    c4_q   <= c3_q;
    d4_q   <= d3_q;
    e4_q   <= e3_q;
    uvw4_q <= uvw3_q;
  end

  // stage 5: determinant and raw numerators
  logic signed [NW-1:0] det_d, det5_q, sn5_q, tn5_q;
  logic signed [SW-1:0] a5_q, b5_q, c5_q, d5_q, e5_q;
  logic                 par5_q;

  assign det_d = NW'(ac_q) - NW'(bb_q);

  always_ff @(posedge clk_i) begin
    det5_q <= det_d;
    sn5_q  <= NW'(be_q) - NW'(cd_q);
    tn5_q  <= NW'(ae_q) - NW'(bd_q);
    par5_q <= det_d < $signed(NW'({1'b0, thr_q}));
    a5_q   <= a4_q;
    b5_q   <= b4_q;
    c5_q   <= c4_q;
    d5_q   <= d4_q;
    e5_q   <= e4_q;
    uvw5_q <= uvw4_q;
  end

  // stage 6: clamp s to the segment
  logic signed [NW-1:0] sn6_d, sd6_d, tn6_d, td6_d, sn6_q, sd6_q, tn6_q, td6_q;
  logic signed [SW:0]   md6_q, mdb6_q;
  logic signed [SW-1:0] a6_q;
  logic                 par6_q;

  always_comb begin
    sn6_d = sn5_q;
    sd6_d = det5_q;
    tn6_d = tn5_q;
    td6_d = det5_q;
    if (par5_q) begin
      sn6_d = '0;
      sd6_d = NW'(1);
      tn6_d = NW'(e5_q);
      td6_d = NW'(c5_q);
    end else if (sn5_q[NW-1]) begin
      sn6_d = '0;
      tn6_d = NW'(e5_q);
      td6_d = NW'(c5_q);
    end else if (sn5_q > det5_q) begin
      sn6_d = det5_q;
      tn6_d = NW'(e5_q) + NW'(b5_q);
      td6_d = NW'(c5_q);
    end
  end

  always_ff @(posedge clk_i) begin
    sn6_q  <= sn6_d;
    sd6_q  <= sd6_d;
    tn6_q  <= tn6_d;
    td6_q  <= td6_d;
    md6_q  <= -(SW+1)'(d5_q);
    mdb6_q <= (SW+1)'(b5_q) - (SW+1)'(d5_q);
    a6_q   <= a5_q;
    par6_q <= par5_q;
    uvw6_q <= uvw5_q;
  end

  // stage 7: clamp t and re-solve s
  logic signed [NW-1:0] sn7_d, sd7_d, tn7_d, sn7_q, sd7_q, tn7_q, td7_q;
  logic signed [SW:0]   a6x;
  logic                 par7_q;

  assign a6x = (SW+1)'(a6_q);

  always_comb begin
    sn7_d = sn6_q;
    sd7_d = sd6_q;
    tn7_d = tn6_q;
    if (tn6_q[NW-1]) begin
      tn7_d = '0;
      if (md6_q[SW]) begin
        sn7_d = '0;
      end else if (md6_q > a6x) begin
        sn7_d = sd6_q;
      end else begin
        sn7_d = NW'(md6_q);
        sd7_d = NW'(a6_q);
      end
    end else if (tn6_q > td6_q) begin
      tn7_d = td6_q;
      if (mdb6_q[SW]) begin
        sn7_d = '0;
      end else if (mdb6_q > a6x) begin
        sn7_d = sd6_q;
      end else begin
        sn7_d = NW'(mdb6_q);
        sd7_d = NW'(a6_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sn7_q  <= sn7_d;
    sd7_q  <= sd7_d;
    tn7_q  <= tn7_d;
    td7_q  <= td6_q;
    par7_q <= par6_q;
    uvw7_q <= uvw6_q;
  end

  // parameter fractions
  logic            s_vld, t_vld;
  logic [FRAC_W:0] sc, tc;
  logic [VW-1:0]   uvw_div;
  logic            par_div;

  ssd_div #(
    .NUM_W  (NW),
    .SIDE_W (VW)
  ) u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv_q[6]),
    .num_i   (sn7_q),
    .den_i   (sd7_q),
    .side_i  (uvw7_q),
    .valid_o (s_vld),
    .quo_o   (sc),
    .side_o  (uvw_div)
  );

  ssd_div #(
    .NUM_W  (NW),
    .SIDE_W (1)
  ) u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv_q[6]),
    .num_i   (tn7_q),
    .den_i   (td7_q),
    .side_i  (par7_q),
    .valid_o (t_vld),
    .quo_o   (tc),
    .side_o  (par_div)
  );

  // closest-point difference vector
  logic [4:0]            bv_q;
  logic [4:0]            bp_q;
  logic signed [DW-1:0]  ud [3], vd [3], wd [3];
  logic signed [PRW-1:0] ps1_q [3], pt1_q [3];
  logic signed [DW-1:0]  w1_q [3];
  logic signed [PSW-1:0] p2_q [3];
  logic [PSW-1:0]        mag [3], rnd [3];
  logic [COMP_W-1:0]     m3_q [3];
  logic [2*COMP_W-1:0]   sq4_q [3];
  logic [SQ_W-1:0]       sum5_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ud[k]  = $signed(uvw_div[k*DW +: DW]);
      vd[k]  = $signed(uvw_div[(3+k)*DW +: DW]);
      wd[k]  = $signed(uvw_div[(6+k)*DW +: DW]);
      mag[k] = p2_q[k][PSW-1] ? PSW'(-p2_q[k]) : PSW'(p2_q[k]);
      rnd[k] = (mag[k] + RND_HALF) >> RND_SHIFT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else begin
      bv_q <= {bv_q[3:0], s_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q <= {bp_q[3:0], par_div};
    for (int k = 0; k < 3; k++) begin
      ps1_q[k] <= $signed({1'b0, sc}) * ud[k];
      pt1_q[k] <= $signed({1'b0, tc}) * vd[k];
      w1_q[k]  <= wd[k];
      p2_q[k]  <= (PSW'(w1_q[k]) <<< FRAC_W) + PSW'(ps1_q[k]) - PSW'(pt1_q[k]);
      m3_q[k]  <= (rnd[k] > PSW'(COMP_MAX)) ? COMP_MAX : rnd[k][COMP_W-1:0];
      sq4_q[k] <= m3_q[k] * m3_q[k];
    end
    sum5_q <= SQ_W'(sq4_q[0]) + SQ_W'(sq4_q[1]) + SQ_W'(sq4_q[2]);
  end

  // distance
  logic                root_vld, root_par;
  logic [SQ_STEPS-1:0] root;
  logic [SQ_STEPS:0]   root_rnd;
  logic [SQ_STEPS:0]   dist_full;
  logic                done_q, par_q;
  logic [DIST_W-1:0]   dist_q;

  ssd_sqrt #(
    .SIDE_W (1)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bv_q[4]),
    .rad_i   (sum5_q),
    .side_i  (bp_q[4]),
    .valid_o (root_vld),
    .root_o  (root),
    .side_o  (root_par)
  );

  assign root_rnd  = (SQ_STEPS+1)'(root) + (SQ_STEPS+1)'(1 << (DIST_SHIFT - 1));
  assign dist_full = root_rnd >> DIST_SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= root_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= (dist_full > (SQ_STEPS+1)'(DIST_MAX)) ? DIST_MAX : dist_full[DIST_W-1:0];
    par_q  <= root_par;
  end

  assign done_o          = done_q;
  assign seg_distance_o  = dist_q;
  assign near_parallel_o = par_q;

  `SSD_ASSERT_IMPLIES(a_latency, clk_i, rst_ni, done_o, $past(accept, LAT), "result without request")
  `SSD_ASSERT_NEVER(a_div_align, clk_i, rst_ni, s_vld != t_vld, "divider lanes out of step")
  `SSD_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy, "busy raised")

endmodule

`default_nettype wire

// ----- sv/ssd_div.sv -----
`default_nettype none

module ssd_div #(
  parameter int NUM_W  = 74,
  parameter int SIDE_W = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [NUM_W-1:0]         num_i,
  input  logic [NUM_W-1:0]         den_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic [ssd_pkg::FRAC_W:0] quo_o,
  output logic [SIDE_W-1:0]        side_o
);
  import ssd_pkg::*;

  logic [FRAC_W:0]   vld_q;
  logic [NUM_W:0]    rem_q  [FRAC_W+1];
  logic [NUM_W-1:0]  den_q  [FRAC_W+1];
  logic [FRAC_W-1:0] quo_q  [FRAC_W+1];
  ssd_flag_t         flg_q  [FRAC_W+1];
  logic [SIDE_W-1:0] side_q [FRAC_W+1];
  ssd_flag_t         flg_d;
  logic              npos, dpos;

  // operand checks
  always_comb begin
    npos      = !num_i[NUM_W-1] && (|num_i);
    dpos      = !den_i[NUM_W-1] && (|den_i);
    flg_d.zero = !(npos && dpos);
    flg_d.one  = $signed(num_i) >= $signed(den_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FRAC_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= {1'b0, num_i};
    den_q[0]  <= den_i;
    quo_q[0]  <= '0;
    flg_q[0]  <= flg_d;
    side_q[0] <= side_i;
  end

  for (genvar i = 1; i <= FRAC_W; i++) begin : g_step
    logic [NUM_W:0] shl, dif;
    logic           ge;
    always_comb begin
      shl = {rem_q[i-1][NUM_W-1:0], 1'b0};
      dif = shl - {1'b0, den_q[i-1]};
      ge  = shl >= {1'b0, den_q[i-1]};
    end
    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? dif : shl;
      den_q[i]  <= den_q[i-1];
      quo_q[i]  <= {quo_q[i-1][FRAC_W-2:0], ge};
      flg_q[i]  <= flg_q[i-1];
      side_q[i] <= side_q[i-1];
    end
  end

  always_comb begin
    if (flg_q[FRAC_W].zero) begin
      quo_o = '0;
    end else if (flg_q[FRAC_W].one) begin
      quo_o = {1'b1, {FRAC_W{1'b0}}};
    end else begin
      quo_o = {1'b0, quo_q[FRAC_W]};
    end
  end

  assign valid_o = vld_q[FRAC_W];
  assign side_o  = side_q[FRAC_W];

endmodule

`default_nettype wire

// ----- sv/ssd_sqrt.sv -----
`default_nettype none

module ssd_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [ssd_pkg::SQ_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         valid_o,
  output logic [ssd_pkg::SQ_STEPS-1:0] root_o,
  output logic [SIDE_W-1:0]            side_o
);
  import ssd_pkg::*;

  logic [SQ_STEPS-1:0] vld_q;
  logic [SQ_W-1:0]     x_q    [SQ_STEPS];
  logic [SQ_W-1:0]     r_q    [SQ_STEPS];
  logic [SIDE_W-1:0]   side_q [SQ_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SQ_STEPS-2:0], valid_i};
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (SQ_STEPS - 1 - i));
    logic [SQ_W-1:0]   x_in, r_in, trial, x_d, r_d;
    logic [SIDE_W-1:0] s_in;
    if (i == 0) begin : g_first
      assign x_in = rad_i;
      assign r_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign r_in = r_q[i-1];
      assign s_in = side_q[i-1];
    end
    always_comb begin
      trial = r_in + BITV;
      if (x_in >= trial) begin
        x_d = x_in - trial;
        r_d = (r_in >> 1) + BITV;
      end else begin
        x_d = x_in;
        r_d = r_in >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      x_q[i]    <= x_d;
      r_q[i]    <= r_d;
      side_q[i] <= s_in;
    end
  end

  assign valid_o = vld_q[SQ_STEPS-1];
  assign root_o  = r_q[SQ_STEPS-1][SQ_STEPS-1:0];
  assign side_o  = side_q[SQ_STEPS-1];

endmodule

`default_nettype wire
